### rtl/core/first_seen_palette_builder_macros.svh
// assertion macros for the first-seen palette builder
// clocked on clk and disabled during rst of the module that uses them
`ifndef FIRST_SEEN_PALETTE_BUILDER_MACROS_SVH
`define FIRST_SEEN_PALETTE_BUILDER_MACROS_SVH

// same-cycle implication
`define FSPB_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FSPB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/fspb_pkg.sv
// shared types, sizes and color expansion functions for the palette builder
// no dependencies
package fspb_pkg;

  localparam int CAPACITY    = 256;
  localparam int IDX_W       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W       = $clog2(CAPACITY + 1);
  localparam int PIX_W       = 16;
  localparam int MAP_DEPTH   = 2 ** PIX_W;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // reciprocals for the rounded expansion, exact over the whole input range
  localparam int RECIP_SHIFT = 20;
  localparam int RECIP31     = (2 ** RECIP_SHIFT + 30) / 31;
  localparam int RECIP63     = (2 ** RECIP_SHIFT + 62) / 63;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_565;
    logic             new_set;
  } pix_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       is_new;
    logic [7:0] colour_index;
    logic [8:0] colour_count;
    logic       overflow;
  } res_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_565;
    logic             new_set;
    logic [7:0]       red;
    logic [7:0]       green;
    logic [7:0]       blue;
  } ent_t;

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_MAP,
    BK_DECIDE
  } bk_state_t;

  // (v*255+15)/31
  function automatic logic [7:0] expand5(input logic [4:0] v);
    logic [13:0] x;
    logic [29:0] p;
    x = 14'(v) * 14'd255 + 14'd15;
    p = 30'(x) * 30'(RECIP31);
    return p[RECIP_SHIFT +: 8];
  endfunction

  // (v*255+31)/63
  function automatic logic [7:0] expand6(input logic [5:0] v);
    logic [13:0] x;
    logic [29:0] p;
    x = 14'(v) * 14'd255 + 14'd31;
    p = 30'(x) * 30'(RECIP63);
    return p[RECIP_SHIFT +: 8];
  endfunction

endpackage

### rtl/core/fspb_front.sv
// front stage: takes pixel beats, expands RGB565 to RGB888 and registers them
// depends on fspb_pkg
module fspb_front import fspb_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic pix_valid,
  output logic pix_ready,
  input  pix_t pix,
  output logic f_valid,
  input  logic f_ready,
  output ent_t f_ent
);

  assign pix_ready = !f_valid || f_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (pix_ready) begin
      f_valid <= pix_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pix_valid && pix_ready) begin
      f_ent.pixel_565 <= pix.pixel_565;
      f_ent.new_set   <= pix.new_set;
      f_ent.red       <= expand5(pix.pixel_565[15:11]);
      f_ent.green     <= expand6(pix.pixel_565[10:5]);
      f_ent.blue      <= expand5(pix.pixel_565[4:0]);
    end
  end

endmodule

### rtl/core/fspb_queue.sv
// short fifo between the front stage and the lookup engine
// depends on fspb_pkg
module fspb_queue import fspb_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  ent_t push_ent,
  output logic pop_valid,
  input  logic pop,
  output ent_t pop_ent
);

  ent_t              q_mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   fill;
  logic              do_push;
  logic              do_pop;

  assign push_ready = fill != (QPTR_W + 1)'(QUEUE_DEPTH);
  assign pop_valid  = fill != '0;
  assign pop_ent    = q_mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_mem[wr_ptr] <= push_ent;
    end
  end

endmodule

### rtl/core/fspb_back.sv
// lookup engine: color-to-index map plus first-seen palette, one pixel at a time
// depends on fspb_pkg and first_seen_palette_builder_macros.svh
`include "first_seen_palette_builder_macros.svh"

module fspb_back import fspb_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic q_valid,
  output logic q_pop,
  input  ent_t q_ent,
  output logic res_valid,
  input  logic res_ready,
  output res_t res
);

  bk_state_t        state;
  bk_state_t        state_next;
  logic [PIX_W-1:0] clr_addr;
  ent_t             cur;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             ovf;
  logic             ovf_next;
  logic             tbl_re;
  logic             ld;
  logic             hit;
  logic             room;
  logic             append;
  logic [IDX_W-1:0] idx;

  // map: color code -> palette slot it was last given (may be stale)
  logic [IDX_W-1:0] map_mem [MAP_DEPTH];
  logic [IDX_W-1:0] map_q;
  logic             map_we;
  logic [PIX_W-1:0] map_waddr;
  logic [IDX_W-1:0] map_wdata;

  // palette in first-seen order
  logic [PIX_W-1:0] tbl_mem [CAPACITY];
  logic [PIX_W-1:0] tbl_q;
  logic             tbl_we;

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    tbl_re     = 1'b0;
    ld         = 1'b0;
    case (state)
      BK_CLEAR: begin
        if (clr_addr == '1) begin
          state_next = BK_IDLE;
        end
      end
      BK_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          state_next = BK_MAP;
        end
      end
      BK_MAP: begin
        tbl_re     = 1'b1;
        state_next = BK_DECIDE;
      end
      BK_DECIDE: begin
        if (!res_valid || res_ready) begin
          ld         = 1'b1;
          state_next = BK_IDLE;
        end
      end
      default: begin
        state_next = BK_CLEAR;
      end
    endcase
  end

  // a map entry only counts if the slot it names is live and holds this color
  always_comb begin
    hit        = (CNT_W'(map_q) < count) && (tbl_q == cur.pixel_565);
    room       = count < CNT_W'(CAPACITY);
    append     = !hit && room;
    idx        = hit ? map_q : (room ? count[IDX_W-1:0] : '0);
    count_next = append ? count + CNT_W'(1) : count;
    ovf_next   = ovf || (!hit && !room);
  end

  assign tbl_we    = ld && append;
  assign map_we    = (state == BK_CLEAR) || tbl_we;
  assign map_waddr = (state == BK_CLEAR) ? clr_addr : cur.pixel_565;
  assign map_wdata = (state == BK_CLEAR) ? '0 : count[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (map_we) begin
      map_mem[map_waddr] <= map_wdata;
    end
    if (q_pop) begin
      map_q <= map_mem[q_ent.pixel_565];
    end
  end

  always_ff @(posedge clk) begin
    if (tbl_we) begin
      tbl_mem[count[IDX_W-1:0]] <= cur.pixel_565;
    end
    if (tbl_re) begin
      tbl_q <= tbl_mem[map_q];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_CLEAR;
      clr_addr  <= '0;
      count     <= '0;
      ovf       <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == BK_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (q_pop && q_ent.new_set) begin
        count <= '0;
        ovf   <= 1'b0;
      end else if (ld) begin
        count <= count_next;
        ovf   <= ovf_next;
      end
      if (ld) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_ent;
    end
    if (ld) begin
      res.red          <= cur.red;
      res.green        <= cur.green;
      res.blue         <= cur.blue;
      res.is_new       <= !hit;
      res.colour_index <= 8'(idx);
      res.colour_count <= 9'(count_next);
      res.overflow     <= ovf_next;
    end
  end

  `FSPB_ASSERT_IMPL(a_count_range, 1'b1, count <= CNT_W'(CAPACITY), "count above capacity")
  `FSPB_ASSERT_IMPL(a_ovf_full, ovf, count == CNT_W'(CAPACITY), "overflow with room left")
  `FSPB_ASSERT_IMPL(a_no_pop_clear, state == BK_CLEAR, !q_pop, "beat taken while clearing map")
  `FSPB_ASSERT_NEXT(a_load_valid, ld, res_valid, "loaded result not presented")

endmodule

### rtl/core/first_seen_palette_builder.sv
// top level of the first-seen palette builder
// depends on fspb_pkg, fspb_front, fspb_queue and fspb_back
//
// One RGB565 pixel beat in, one result beat out: the RGB888 expansion, the
// color's position in the first-seen palette of the current frame set, whether
// it is new, the stored count and a sticky overflow flag. A beat with new_set
// empties the palette before its own pixel. In the lookup engine each pixel
// passes through a read of the 64K-entry color map, a read of the palette and
// the decide-and-update step, which waits while the output is held. Up to five
// beats are taken ahead of the engine (front register plus a 4-entry queue).
// After reset the color map is swept once, all 65536 entries, before the first
// pixel is looked up; beats are still taken into the queue during the sweep.
module first_seen_palette_builder import fspb_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic pix_valid,
  output logic pix_ready,
  input  pix_t pix,
  output logic res_valid,
  input  logic res_ready,
  output res_t res
);

  logic f_valid;
  logic f_ready;
  ent_t f_ent;
  logic q_valid;
  logic q_pop;
  ent_t q_ent;

  fspb_front u_front (
    .clk       (clk),
    .rst       (rst),
    .pix_valid (pix_valid),
    .pix_ready (pix_ready),
    .pix       (pix),
    .f_valid   (f_valid),
    .f_ready   (f_ready),
    .f_ent     (f_ent)
  );

  fspb_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_ent   (f_ent),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_ent    (q_ent)
  );

  fspb_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_ent     (q_ent),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

endmodule
